@@ hdl/ssps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ssps_pkg;

  localparam int ORDER   = 6;
  localparam int NTERM   = ORDER + 1;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 32;
  localparam int ROW_W   = 3;
  localparam int COL_W   = 3;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ORDER - 1);
  localparam logic [COL_W-1:0] U_COL    = COL_W'(ORDER);

  // Plant coefficients scaled by 10000. The last column is the drive vector.
  localparam int COEF_E4 [ORDER][NTERM] = '{
    '{  9652,  -172,    57,   -58,    52,  -251, 471 },
    '{  7732,  1252,  2315,   700,  1282,  7754, 377 },
    '{  8278, -7522,  -956,  3299, -4855,  3915, 404 },
    '{  9948,  2655, -3848,  4212,  3927,  2899, 485 },
    '{  7648, -4165, -4855, -3366,  -986,  7281, 373 },
    '{ 11056,  7587,  1179,   748, -2192,  1491, 539 }
  };

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic             load_u;
    logic             issue;
    logic             first;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // Rounds a scaled decimal to the given number of fraction bits, halves away from zero.
  function automatic longint quantize(input int v, input int frac);
    longint m;
    longint q;
    begin
      m = (v < 0) ? -longint'(v) : longint'(v);
      q = ((m <<< frac) + 64'sd5000) / 64'sd10000;
      return (v < 0) ? -q : q;
    end
  endfunction

endpackage

`default_nettype wire

@@ hdl/ssps_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ssps_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  ssps_pkg::status_t   status,
  output ssps_pkg::cmd_t      cmd
);

  ssps_pkg::state_t                 state_r, state_nxt;
  logic [ssps_pkg::ROW_W-1:0]       row_r, row_nxt;
  logic [ssps_pkg::COL_W-1:0]       col_r, col_nxt;
  logic                             drain_r, drain_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssps_pkg::S_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      drain_r <= drain_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssps_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = ssps_pkg::S_RUN;
      end
      ssps_pkg::S_RUN: begin
        if (row_r == ssps_pkg::LAST_ROW && col_r == ssps_pkg::U_COL) begin
          state_nxt = ssps_pkg::S_DRAIN;
        end
      end
      ssps_pkg::S_DRAIN: begin
        if (drain_r) state_nxt = ssps_pkg::S_COMMIT;
      end
      ssps_pkg::S_COMMIT: begin
        if (status.out_free) state_nxt = ssps_pkg::S_IDLE;
      end
      default: state_nxt = ssps_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    row_nxt   = row_r;
    col_nxt   = col_r;
    drain_nxt = 1'b0;
    unique case (state_r)
      ssps_pkg::S_IDLE: begin
        row_nxt = '0;
        col_nxt = '0;
      end
      ssps_pkg::S_RUN: begin
        if (col_r == ssps_pkg::U_COL) begin
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      ssps_pkg::S_DRAIN: begin
        drain_nxt = !drain_r;
      end
      ssps_pkg::S_COMMIT: begin
        drain_nxt = 1'b0;
      end
      default: drain_nxt = 1'b0;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    cmd.row    = row_r;
    cmd.col    = col_r;
    cmd.first  = (col_r == '0);
    cmd.last   = (col_r == ssps_pkg::U_COL);
    unique case (state_r)
      ssps_pkg::S_IDLE: begin
        in_tready  = 1'b1;
        cmd.load_u = in_tvalid;
      end
      ssps_pkg::S_RUN: begin
        cmd.issue = 1'b1;
      end
      ssps_pkg::S_DRAIN: begin
        cmd.issue = 1'b0;
      end
      ssps_pkg::S_COMMIT: begin
        cmd.commit = status.out_free;
      end
      default: cmd.issue = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/ssps_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ssps_dp #(
  parameter int STATE_WIDTH    = 32,
  parameter int COEF_FRAC_BITS = 14
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  ssps_pkg::cmd_t               cmd,
  output ssps_pkg::status_t            status,
  input  wire [ssps_pkg::IN_W-1:0]     in_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [ssps_pkg::OUT_W-1:0]   out_data,
  output logic                         out_sat
);

  localparam int OPW    = (STATE_WIDTH > ssps_pkg::IN_W) ? STATE_WIDTH : ssps_pkg::IN_W;
  localparam int COEF_W = COEF_FRAC_BITS + 2;
  localparam int PROD_W = OPW + COEF_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int SH_W   = ACC_W - COEF_FRAC_BITS;

  localparam logic signed [ACC_W-1:0] HALF =
    ACC_W'(longint'(1) <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [SH_W-1:0] SMAX =
    SH_W'((longint'(1) <<< (STATE_WIDTH - 1)) - 1);
  localparam logic signed [SH_W-1:0] SMIN = -SMAX - SH_W'(1);

  logic signed [COEF_W-1:0] coef_tab [ssps_pkg::ORDER][ssps_pkg::NTERM];

  for (genvar gr = 0; gr < ssps_pkg::ORDER; gr++) begin : g_row
    for (genvar gc = 0; gc < ssps_pkg::NTERM; gc++) begin : g_col
      assign coef_tab[gr][gc] =
        COEF_W'(ssps_pkg::quantize(ssps_pkg::COEF_E4[gr][gc], COEF_FRAC_BITS));
    end
  end

  logic signed [STATE_WIDTH-1:0]  state_r [ssps_pkg::ORDER];
  logic signed [STATE_WIDTH-1:0]  next_r  [ssps_pkg::ORDER];
  logic signed [ssps_pkg::IN_W-1:0] u_r;

  logic signed [OPW-1:0]    op_sel;
  logic signed [COEF_W-1:0] coef_sel;
  logic signed [PROD_W-1:0] prod_nxt, prod_r;
  logic                     s1_valid_r, s1_first_r, s1_last_r;
  logic [ssps_pkg::ROW_W-1:0] s1_row_r, s2_row_r;
  logic signed [ACC_W-1:0]  acc_nxt, acc_r;
  logic                     s2_fin_r;

  logic signed [ACC_W-1:0]       rnd;
  logic signed [SH_W-1:0]        shifted;
  logic signed [STATE_WIDTH-1:0] row_val;
  logic                          row_clamp;
  logic                          sat_r;

  logic                          out_valid_r;
  logic [ssps_pkg::OUT_W-1:0]    out_data_r;
  logic                          out_sat_r;

  always_comb begin
    if (cmd.col == ssps_pkg::U_COL) begin
      op_sel = OPW'(u_r);
    end else begin
      op_sel = OPW'(state_r[cmd.col]);
    end
    coef_sel = coef_tab[cmd.row][cmd.col];
    prod_nxt = op_sel * coef_sel;
  end

  always_comb begin
    if (s1_first_r) begin
      acc_nxt = ACC_W'(prod_r);
    end else begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_comb begin
    rnd     = acc_r + HALF;
    shifted = SH_W'(rnd >>> COEF_FRAC_BITS);
    if (shifted > SMAX) begin
      row_val   = STATE_WIDTH'(SMAX);
      row_clamp = 1'b1;
    end else if (shifted < SMIN) begin
      row_val   = STATE_WIDTH'(SMIN);
      row_clamp = 1'b1;
    end else begin
      row_val   = STATE_WIDTH'(shifted);
      row_clamp = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_fin_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ssps_pkg::ORDER; i++) begin
        state_r[i] <= '0;
      end
    end else begin
      s1_valid_r <= cmd.issue;
      s2_fin_r   <= s1_valid_r && s1_last_r;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        for (int i = 0; i < ssps_pkg::ORDER; i++) begin
          state_r[i] <= next_r[i];
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_u) begin
      u_r <= in_data;
    end
    prod_r     <= prod_nxt;
    s1_first_r <= cmd.first;
    s1_last_r  <= cmd.last;
    s1_row_r   <= cmd.row;
    s2_row_r   <= s1_row_r;
    if (s1_valid_r) begin
      acc_r <= acc_nxt;
    end
    if (cmd.load_u) begin
      sat_r <= 1'b0;
    end else if (s2_fin_r) begin
      sat_r <= sat_r | row_clamp;
    end
    if (s2_fin_r) begin
      next_r[s2_row_r] <= row_val;
    end
    if (cmd.commit) begin
      out_data_r <= ssps_pkg::OUT_W'(next_r[ssps_pkg::LAST_ROW]);
      out_sat_r  <= sat_r;
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign out_sat         = out_sat_r;

endmodule

`default_nettype wire

@@ hdl/state_space_plant_step_top.sv @@
// Sixth-order state-space plant step in fixed point.
// Input channel in_*: one transaction carries one drive sample (signed Q16.16).
// Output channel out_*: one transaction per input, carrying the new sixth state
// element (signed Q16.16) in out_tdata and a saturation flag in out_tuser.
// Each accepted sample computes x_new = A*x + B*u over 42 products on one shared
// multiplier followed by an accumulator and a round and clamp stage.
// The block takes one sample at a time: in_tready is high only while idle.
// out_tvalid rises after the edge that accepts the input transaction, once all
// the multiply issues, the pipeline drain and the commit have passed.
// Throughput is bound by the single multiplier; the next sample waits for idle.
// The result sits in an output register, so the next sample can be accepted
// while an earlier result still waits; if that result is still not taken when
// the next commit is due, the block holds the commit until out_tready.
// Reset clears the state vector to zero and drops out_tvalid.
`timescale 1ns / 1ps
`default_nettype none

module state_space_plant_step_top #(
  parameter int STATE_WIDTH    = 32,
  parameter int COEF_FRAC_BITS = 14
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] drive_sample
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // [31:0] plant_output
  output logic [0:0]  out_tuser   // [0] saturated
);

  ssps_pkg::cmd_t    cmd;
  ssps_pkg::status_t status;
  logic              out_sat;

  ssps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ssps_dp #(
    .STATE_WIDTH    (STATE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_sat   (out_sat)
  );

  assign out_tuser = out_sat;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted again right after a transaction");

  a_issue_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !in_tready)
    else $error("multiply issued while idle");

  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_tvalid || out_tready))
    else $error("commit would overwrite a pending result");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_state_space_plant_step_top.sv @@
`timescale 1ns / 1ps

module tb_state_space_plant_step_top;

  localparam int ORDER       = 6;
  localparam int FRAC_BITS   = 14;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_ITEMS  = 1100;
  localparam logic [31:0] DRIVE_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] DRIVE_MIN = 32'h8000_0000;

  // Plant matrix scaled by 10000; the last column is the drive vector.
  localparam int PLANT_E4 [ORDER][ORDER+1] = '{
    '{  9652,  -172,    57,   -58,    52,  -251, 471 },
    '{  7732,  1252,  2315,   700,  1282,  7754, 377 },
    '{  8278, -7522,  -956,  3299, -4855,  3915, 404 },
    '{  9948,  2655, -3848,  4212,  3927,  2899, 485 },
    '{  7648, -4165, -4855, -3366,  -986,  7281, 373 },
    '{ 11056,  7587,  1179,   748, -2192,  1491, 539 }
  };

  typedef struct {
    logic [31:0] voltage;
    logic        sat;
  } plant_result_t;

  class plant_scoreboard;
    longint        plant_state [ORDER];
    longint        coef_q [ORDER][ORDER+1];
    plant_result_t pending_outputs [$];
    int            errors;

    function new();
      longint mag;
      longint q;
      for (int r = 0; r < ORDER; r++) begin
        for (int k = 0; k <= ORDER; k++) begin
          mag = (PLANT_E4[r][k] < 0) ? -longint'(PLANT_E4[r][k]) : longint'(PLANT_E4[r][k]);
          q = ((mag << FRAC_BITS) + 5000) / 10000;
          coef_q[r][k] = (PLANT_E4[r][k] < 0) ? -q : q;
        end
      end
      foreach (plant_state[i]) plant_state[i] = 0;
      errors = 0;
    endfunction

    // All rows use the old state; the new state replaces it only at the end.
    function void note_drive(logic [31:0] drive);
      longint        acc;
      longint        rounded;
      longint        next_state [ORDER];
      logic          clamped;
      plant_result_t res;
      clamped = 1'b0;
      for (int r = 0; r < ORDER; r++) begin
        acc = 0;
        for (int k = 0; k < ORDER; k++) acc += plant_state[k] * coef_q[r][k];
        acc += longint'($signed(drive)) * coef_q[r][ORDER];
        rounded = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (rounded > 64'sd2147483647) begin
          rounded = 64'sd2147483647;
          clamped = 1'b1;
        end else if (rounded < -64'sd2147483648) begin
          rounded = -64'sd2147483648;
          clamped = 1'b1;
        end
        next_state[r] = rounded;
      end
      foreach (plant_state[i]) plant_state[i] = next_state[i];
      res.voltage = next_state[ORDER-1][31:0];
      res.sat = clamped;
      pending_outputs.push_back(res);
    endfunction

    function void check_output(logic [31:0] voltage, logic sat);
      plant_result_t exp_res;
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected result plant_output %h saturated %b", $time, voltage, sat);
        errors++;
        return;
      end
      exp_res = pending_outputs.pop_front();
      if (voltage !== exp_res.voltage) begin
        $display("%0t: plant_output expected %h actual %h", $time, exp_res.voltage, voltage);
        errors++;
      end
      if (sat !== exp_res.sat) begin
        $display("%0t: saturated expected %b actual %b", $time, exp_res.sat, sat);
        errors++;
      end
    endfunction

    function int pending_count();
      return pending_outputs.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;

  plant_scoreboard board = new();
  int drives_accepted = 0;
  int results_seen = 0;
  int cycle_count = 0;
  logic quiet;

  assign quiet = (drives_accepted >= 600) && (drives_accepted < 750);

  state_space_plant_step_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_state_space_plant_step_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_output(out_tdata, out_tuser[0]);
      results_seen++;
    end
  end

  // The long hold-off lets the output register fill so that the block stalls its input.
  int  hold_left = 0;
  bit  hold_done = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (!hold_done && results_seen >= 150) begin
        hold_left = 400;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= quiet || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_drive(input logic [31:0] drive);
    int gap;
    if (!quiet && $urandom_range(0, 99) < 15) begin
      gap = $urandom_range(1, 60);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= drive;
    do @(posedge clk); while (!in_tready);
    board.note_drive(drive);
    drives_accepted++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_drive();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return $urandom();
    if (sel < 80) return 32'($signed($urandom_range(0, 131071)) - 65536);
    case ($urandom_range(0, 4))
      0: return DRIVE_MAX;
      1: return DRIVE_MIN;
      2: return 32'h0000_0001;
      3: return 32'hFFFF_FFFF;
      default: return 32'h0000_0000;
    endcase
  endfunction

  logic [31:0] directed_drives [$] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, DRIVE_MAX, DRIVE_MIN,
    32'h0000_8000, 32'h5555_5555, 32'hAAAA_AAAA
  };

  initial begin
    int          run_left;
    logic [31:0] run_value;
    run_left = 0;
    run_value = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_drives[i]) send_drive(directed_drives[i]);
    repeat (8) send_drive(DRIVE_MAX);
    repeat (8) send_drive(DRIVE_MIN);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (run_left == 0 && $urandom_range(0, 99) < 4) begin
        run_left = $urandom_range(5, 30);
        run_value = $urandom_range(0, 1) ? DRIVE_MAX : DRIVE_MIN;
      end
      if (run_left > 0) begin
        run_left--;
        send_drive(run_value);
      end else begin
        send_drive(pick_drive());
      end
    end
    in_tvalid <= 1'b0;

    while (board.pending_count() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (board.errors == 0 && board.pending_count() == 0) begin
      $display("tb_state_space_plant_step_top: PASS");
    end else begin
      $display("tb_state_space_plant_step_top: FAIL");
    end
    $finish;
  end

endmodule
